// File: hw/rtl/snp_pkg.sv
// ---------------------------------------------------------------------------
// snp_pkg
// Shared types and constants of the snapshot delta top-k ranker.
// ---------------------------------------------------------------------------
package snp_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RANK_SLOTS  = 5;
  localparam int SLOT_W      = 3;
  localparam int MEM_TOT_W   = 40;
  localparam int CPU_CNT_W   = 11;
  localparam int MF_W        = 11;
  localparam int CAP_W       = 25;
  localparam int CBIT_W      = $clog2(CAP_W);
  localparam int CPU_SCALE   = 10000;
  localparam int MEM_SCALE   = 100;
  localparam int NUM_W       = 48;

  localparam logic [7:0]  ST_ZOMBIE = 8'h5A;
  localparam logic [7:0]  ST_UNRESP = 8'h44;
  localparam logic [7:0]  MEM_SAT   = 8'd255;
  localparam logic [15:0] CPU_SAT   = 16'hFFFF;

  typedef enum logic {
    REG_MEM_TOTAL = 1'b0,
    REG_CPU_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] proc_id;
    logic [63:0] cpu_ticks;
    logic [7:0]  state_code;
    logic        privileged;
    logic [39:0] resident_kb;
    logic [63:0] system_ticks;
    logic        scan_last;
  } rec_t;

  typedef struct packed {
    logic [2:0]  slot_index;
    logic [31:0] slot_pid;
    logic [15:0] cpu_hundredths;
    logic [7:0]  memory_percent;
    logic [2:0]  status_flags;
    logic [15:0] total_processes;
    logic        slot_last;
  } slot_t;

  typedef struct packed {
    logic [31:0]     id;
    logic [63:0]     ticks;
    logic [MF_W-1:0] mf;
  } ent_t;

  typedef struct packed {
    logic rec_load;
    logic mdiv_step;
    logic rec_store;
    logic scan_begin;
    logic base_cap;
    logic srch;
    logic insert;
    logic cpu_init;
    logic cpu_step;
    logic out_load;
    logic k_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic rec_last;
    logic mdiv_last;
    logic first;
    logic base_more;
    logic srch_done;
    logic cpu_done;
    logic k_last;
  } sts_t;

endpackage

// File: hw/rtl/snp_ram.sv
// ---------------------------------------------------------------------------
// snp_ram
// Single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module snp_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 107
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/snp_dp.sv
// ---------------------------------------------------------------------------
// snp_dp
// Datapath: record tables, memory percent divider, match walk, top-five
// ranking registers, CPU share divider and the slot output register.
// ---------------------------------------------------------------------------
module snp_dp import snp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rec_t                 rec_in,
  input  logic [MEM_TOT_W-1:0] mem_total,
  input  logic [CPU_CNT_W-1:0] cpu_count,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output slot_t                slot
);

  // Record being processed and the memory percent divider.
  rec_t             r;
  logic [NUM_W-1:0] n_orig;
  logic [NUM_W-1:0] div_r;
  logic [NUM_W-1:0] div_d;
  logic [7:0]       div_q;
  logic [2:0]       div_cnt;
  logic [7:0]       mp;
  logic [MF_W-1:0]  mf_new;
  logic             store_en;

  // Scan bookkeeping.
  logic             bank_sel;
  logic [CNT_W-1:0] scan_count;
  logic [CNT_W-1:0] base_count;
  logic [63:0]      base_sys;
  logic [15:0]      rec_cnt;
  logic [63:0]      sysd;
  logic [63:0]      sys_diff;
  logic [CAP_W-1:0] cap_q;
  logic [CPU_CNT_W-1:0] ncpu;

  // Match walk.
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic             rd_vld;
  logic [31:0]      b_id;
  logic [63:0]      b_ticks;
  logic             f_ok;
  logic [63:0]      f_delta;
  logic [MF_W-1:0]  f_mf;
  logic             s_hit;
  logic             s_more;
  logic [64:0]      d65;

  // Tables.
  ent_t             wr_ent;
  ent_t             rd0;
  ent_t             rd1;
  ent_t             base_data;
  ent_t             scan_data;
  logic [IDX_W-1:0] raddr0;
  logic [IDX_W-1:0] raddr1;

  // Ranking.
  logic [31:0]           top_pid   [RANK_SLOTS];
  logic [63:0]           top_delta [RANK_SLOTS];
  logic [MF_W-1:0]       top_mf    [RANK_SLOTS];
  logic [RANK_SLOTS-1:0] top_vld;
  logic [SLOT_W-1:0]     ins_pos;
  logic                  ins_hit;

  // CPU share divider.
  logic [SLOT_W-1:0] k;
  logic [63:0]       c_r;
  logic [63:0]       c_num;
  logic [CAP_W-1:0]  c_q;
  logic [CBIT_W-1:0] c_bit;
  logic              c_ph;
  logic              c_busy;
  logic [64:0]       c_t;
  logic              c_ge;
  logic [63:0]       c_rn;
  logic [CAP_W-1:0]  c_v;
  logic [15:0]       cpu16;

  // Memory percent: saturates when the quotient would reach 256.
  always_comb begin
    if (mem_total == '0) begin
      mp = '0;
    end else if (n_orig >= (NUM_W'(mem_total) << 8)) begin
      mp = MEM_SAT;
    end else begin
      mp = div_q;
    end
    mf_new = {mp, r.privileged, (r.state_code == ST_UNRESP), (r.state_code == ST_ZOMBIE)};
    store_en = cmd.rec_store && (r.proc_id != '0) && (scan_count < CNT_W'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_load) begin
      r       <= rec_in;
      n_orig  <= NUM_W'(rec_in.resident_kb) * NUM_W'(MEM_SCALE);
      div_r   <= NUM_W'(rec_in.resident_kb) * NUM_W'(MEM_SCALE);
      div_d   <= NUM_W'(mem_total) << 7;
      div_q   <= '0;
      div_cnt <= '0;
    end else if (cmd.mdiv_step) begin
      if (div_r >= div_d) begin
        div_r <= div_r - div_d;
        div_q <= {div_q[6:0], 1'b1};
      end else begin
        div_q <= {div_q[6:0], 1'b0};
      end
      div_d   <= div_d >> 1;
      div_cnt <= div_cnt + 3'd1;
    end
  end

  assign ncpu     = (cpu_count == '0) ? CPU_CNT_W'(1) : cpu_count;
  assign sys_diff = r.system_ticks - base_sys;

  always_ff @(posedge clk) begin
    cap_q <= CAP_W'(CAP_W'(CPU_SCALE) * CAP_W'(ncpu));
    if (cmd.scan_begin) begin
      sysd <= (sys_diff == '0) ? 64'd1 : sys_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_sel   <= 1'b0;
      scan_count <= '0;
      base_count <= '0;
      base_sys   <= '0;
      rec_cnt    <= '0;
    end else if (cmd.finish) begin
      bank_sel   <= ~bank_sel;
      base_count <= scan_count;
      base_sys   <= r.system_ticks;
      scan_count <= '0;
      rec_cnt    <= '0;
    end else if (cmd.rec_store) begin
      if (r.proc_id != '0) begin
        rec_cnt <= rec_cnt + 16'd1;
      end
      if (store_en) begin
        scan_count <= scan_count + CNT_W'(1);
      end
    end
  end

  // Ping-pong tables: the baseline bank is bank_sel, the scan fills the other.
  assign wr_ent    = '{id: r.proc_id, ticks: r.cpu_ticks, mf: mf_new};
  assign raddr0    = bank_sel ? j[IDX_W-1:0] : i[IDX_W-1:0];
  assign raddr1    = bank_sel ? i[IDX_W-1:0] : j[IDX_W-1:0];
  assign base_data = bank_sel ? rd1 : rd0;
  assign scan_data = bank_sel ? rd0 : rd1;

  snp_ram #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(ent_t))) u_bank0 (
    .clk   (clk),
    .we    (store_en && bank_sel),
    .waddr (scan_count[IDX_W-1:0]),
    .wdata (wr_ent),
    .raddr (raddr0),
    .rdata (rd0)
  );

  snp_ram #(.DEPTH(TABLE_DEPTH), .WIDTH($bits(ent_t))) u_bank1 (
    .clk   (clk),
    .we    (store_en && !bank_sel),
    .waddr (scan_count[IDX_W-1:0]),
    .wdata (wr_ent),
    .raddr (raddr1),
    .rdata (rd1)
  );

  // Search streams one scan entry per cycle; read data is registered and arrives in the cycle after its address.
  assign s_hit  = rd_vld && (scan_data.id == b_id);
  assign s_more = (j < scan_count);
  assign d65    = {1'b0, scan_data.ticks} - {1'b0, b_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      i      <= '0;
      j      <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.scan_begin) begin
        i <= '0;
      end else if (cmd.insert) begin
        i <= i + CNT_W'(1);
      end
      if (cmd.base_cap) begin
        j      <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.srch && !s_hit) begin
        if (s_more) begin
          j      <= j + CNT_W'(1);
          rd_vld <= 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.base_cap) begin
      b_id    <= base_data.id;
      b_ticks <= base_data.ticks;
      f_ok    <= 1'b0;
    end else if (cmd.srch && s_hit) begin
      f_ok    <= (scan_data.ticks != '0);
      f_delta <= d65[64] ? 64'd0 : d65[63:0];
      f_mf    <= scan_data.mf;
    end
  end

  // Stable insertion: a new entry goes ahead only of strictly smaller deltas.
  always_comb begin
    ins_pos = '0;
    ins_hit = 1'b0;
    for (int p = 0; p < RANK_SLOTS; p++) begin
      if (!ins_hit && (!top_vld[p] || (f_delta > top_delta[p]))) begin
        ins_hit = 1'b1;
        ins_pos = SLOT_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_vld <= '0;
    end else if (cmd.scan_begin) begin
      top_vld <= '0;
    end else if (cmd.insert && f_ok && ins_hit) begin
      for (int p = 0; p < RANK_SLOTS; p++) begin
        if (SLOT_W'(p) == ins_pos) begin
          top_vld[p] <= 1'b1;
        end else if (SLOT_W'(p) > ins_pos) begin
          top_vld[p] <= top_vld[(p > 0) ? p - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && f_ok && ins_hit) begin
      for (int p = 0; p < RANK_SLOTS; p++) begin
        if (SLOT_W'(p) == ins_pos) begin
          top_pid[p]   <= b_id;
          top_delta[p] <= f_delta;
          top_mf[p]    <= f_mf;
        end else if (SLOT_W'(p) > ins_pos) begin
          top_pid[p]   <= top_pid[(p > 0) ? p - 1 : 0];
          top_delta[p] <= top_delta[(p > 0) ? p - 1 : 0];
          top_mf[p]    <= top_mf[(p > 0) ? p - 1 : 0];
        end
      end
    end
  end

  // floor(delta * cap / sysd) for delta < sysd, one half-step per cycle:
  // first phase doubles the remainder, second adds delta when the cap bit is set.
  assign c_t  = c_ph ? ({1'b0, c_r} + {1'b0, c_num}) : {c_r, 1'b0};
  assign c_ge = (c_t >= {1'b0, sysd});
  assign c_rn = c_ge ? 64'(c_t - {1'b0, sysd}) : c_t[63:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_busy <= 1'b0;
      k      <= '0;
    end else begin
      if (cmd.scan_begin) begin
        k <= '0;
      end else if (cmd.k_next) begin
        k <= k + SLOT_W'(1);
      end
      if (cmd.cpu_init) begin
        c_busy <= top_vld[k] && (top_delta[k] < sysd);
      end else if (cmd.cpu_step && c_busy && c_ph && (c_bit == '0)) begin
        c_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cpu_init) begin
      c_num <= top_delta[k];
      c_r   <= '0;
      c_bit <= CBIT_W'(CAP_W - 1);
      c_ph  <= 1'b0;
      c_q   <= top_vld[k] ? cap_q : '0;
      if (top_vld[k] && (top_delta[k] < sysd)) begin
        c_q <= '0;
      end
    end else if (cmd.cpu_step && c_busy) begin
      if (!c_ph) begin
        c_r  <= c_rn;
        c_q  <= {c_q[CAP_W-2:0], c_ge};
        c_ph <= 1'b1;
      end else begin
        if (cap_q[c_bit]) begin
          c_r <= c_rn;
          c_q <= c_q + CAP_W'(c_ge);
        end
        c_ph  <= 1'b0;
        c_bit <= c_bit - CBIT_W'(1);
      end
    end
  end

  assign c_v   = (c_q > cap_q) ? cap_q : c_q;
  assign cpu16 = (c_v > CAP_W'(CPU_SAT)) ? CPU_SAT : c_v[15:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      slot.slot_index      <= k;
      slot.slot_pid        <= top_vld[k] ? top_pid[k] : '0;
      slot.cpu_hundredths  <= cpu16;
      slot.memory_percent  <= top_vld[k] ? top_mf[k][MF_W-1:3] : '0;
      slot.status_flags    <= top_vld[k] ? top_mf[k][2:0] : '0;
      slot.total_processes <= rec_cnt;
      slot.slot_last       <= (k == SLOT_W'(RANK_SLOTS - 1));
    end
  end

  always_comb begin
    sts.rec_last  = r.scan_last;
    sts.mdiv_last = (div_cnt == 3'd7);
    sts.first     = (base_count == '0);
    sts.base_more = (i < base_count);
    sts.srch_done = s_hit || (!s_more && !rd_vld);
    sts.cpu_done  = !c_busy;
    sts.k_last    = (k == SLOT_W'(RANK_SLOTS - 1));
  end

  // The valid bits always form a run of ones from slot zero upward.
  a_top_prefix: assert property (@(posedge clk) disable iff (rst)
    ((top_vld & (top_vld + 1'b1)) == '0))
    else $error("ranking valid bits are not a prefix");

  a_empty_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> ((slot.slot_pid != '0) || (slot.cpu_hundredths == '0)))
    else $error("empty slot carries a CPU value");

endmodule

// File: hw/rtl/snp_ctrl.sv
// ---------------------------------------------------------------------------
// snp_ctrl
// Sequencer: record intake, end-of-scan match walk and slot emission.
// ---------------------------------------------------------------------------
module snp_ctrl import snp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic rec_valid,
  output logic rec_ready,
  output logic slot_valid,
  input  logic slot_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_MDIV   = 12'b000000000010,
    S_STORE  = 12'b000000000100,
    S_SBEGIN = 12'b000000001000,
    S_BRD    = 12'b000000010000,
    S_BLAT   = 12'b000000100000,
    S_SRCH   = 12'b000001000000,
    S_INSERT = 12'b000010000000,
    S_CINIT  = 12'b000100000000,
    S_CSTEP  = 12'b001000000000,
    S_OLOAD  = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign rec_ready  = (state == S_IDLE);
  assign slot_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (rec_valid) begin
          cmd.rec_load = 1'b1;
          state_next   = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd.mdiv_step = 1'b1;
        if (sts.mdiv_last) state_next = S_STORE;
      end
      S_STORE: begin
        cmd.rec_store = 1'b1;
        state_next    = sts.rec_last ? S_SBEGIN : S_IDLE;
      end
      S_SBEGIN: begin
        cmd.scan_begin = 1'b1;
        state_next     = sts.first ? S_CINIT : S_BRD;
      end
      S_BRD: begin
        state_next = sts.base_more ? S_BLAT : S_CINIT;
      end
      S_BLAT: begin
        cmd.base_cap = 1'b1;
        state_next   = S_SRCH;
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        if (sts.srch_done) state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_BRD;
      end
      S_CINIT: begin
        cmd.cpu_init = 1'b1;
        state_next   = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.cpu_step = 1'b1;
        if (sts.cpu_done) state_next = S_OLOAD;
      end
      S_OLOAD: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (slot_ready) begin
          if (sts.k_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.k_next = 1'b1;
            state_next = S_CINIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_scan_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && slot_ready && sts.k_last) |=> (state == S_IDLE))
    else $error("final word did not return the block to idle");

  a_rec_take: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_ready) |=> (state == S_MDIV))
    else $error("accepted record did not start the divider");

endmodule

// File: hw/rtl/snapshot_delta_top_k_ranker_core.sv
// ---------------------------------------------------------------------------
// snapshot_delta_top_k_ranker_core
// Per-scan CPU top-five ranker: stores scan records, matches them against
// the previous scan at scan end and emits five ranked slot words.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  rec     | in        | rec_valid / rec_ready     | rec_t, one process record
//  slot    | out       | slot_valid / slot_ready   | slot_t, one ranked slot
//  apb     | in        | psel / penable / pwrite   | 64-bit config registers
//
//  A record passes through accept, 8 steps of the memory percent divider and
//  one table write; the next record is taken only after that write. At scan
//  end each baseline entry is read, captured, searched for among the scan
//  entries and passed to the insert step. A slot runs the serial CPU divider
//  first unless empty or clamped, and each word is offered until taken.
//  Reset is synchronous; the tables need no clearing pass. A stalled slot
//  word holds the block until taken.
// ---------------------------------------------------------------------------
module snapshot_delta_top_k_ranker_core import snp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        rec_valid,
  output logic        rec_ready,
  input  rec_t        rec,
  output logic        slot_valid,
  input  logic        slot_ready,
  output slot_t       slot
);

  logic [MEM_TOT_W-1:0] mem_total;
  logic [CPU_CNT_W-1:0] cpu_cnt;
  logic                 wr_en;
  cmd_t                 cmd;
  sts_t                 sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_total <= MEM_TOT_W'(1);
      cpu_cnt   <= CPU_CNT_W'(1);
    end else if (wr_en) begin
      if (paddr[3] == REG_CPU_COUNT) begin
        cpu_cnt <= pwdata[CPU_CNT_W-1:0];
      end else begin
        mem_total <= pwdata[MEM_TOT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[3] == REG_CPU_COUNT) ? 64'(cpu_cnt) : 64'(mem_total);

  snp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  snp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rec_in    (rec),
    .mem_total (mem_total),
    .cpu_count (cpu_cnt),
    .cmd       (cmd),
    .sts       (sts),
    .slot      (slot)
  );

endmodule

// File: verif/snapshot_delta_top_k_ranker_core_tb.sv
// ---------------------------------------------------------------------------
// snapshot_delta_top_k_ranker_core_tb
// Drives scans of process records through the ranker under several register
// settings, predicts the five ranked slot words of every scan end and checks
// each slot word the block returns, with random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module snapshot_delta_top_k_ranker_core_tb;
  import snp_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        rec_valid;
  logic        rec_ready;
  rec_t        rec;
  logic        slot_valid;
  logic        slot_ready;
  slot_t       slot;

  snapshot_delta_top_k_ranker_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .rec_valid(rec_valid), .rec_ready(rec_ready), .rec(rec),
    .slot_valid(slot_valid), .slot_ready(slot_ready), .slot(slot)
  );

  // Register copies and ranker state kept by the predictor.
  logic [39:0]         mem_total;
  logic [10:0]         cpu_num;
  logic [31:0]         base_id [TABLE_DEPTH];
  logic [63:0]         base_tk [TABLE_DEPTH];
  logic [31:0]         cur_id  [TABLE_DEPTH];
  logic [63:0]         cur_tk  [TABLE_DEPTH];
  logic [MF_W-1:0]     cur_mf  [TABLE_DEPTH];
  int unsigned         base_n;
  int unsigned         cur_n;
  logic [63:0]         base_sys;
  logic [15:0]         rec_cnt;
  logic [31:0]         top_pid [RANK_SLOTS];
  logic [63:0]         top_dl  [RANK_SLOTS];
  logic [MF_W-1:0]     top_mf  [RANK_SLOTS];
  int unsigned         top_n;

  rec_t  pending_recs[$];
  slot_t expected_slots[$];

  int    errors;
  int    slots_seen;
  int    scans_sent;
  int    max_gap;
  int    rec_gap;
  int    slot_gap;
  bit    rec_busy;
  bit    rec_fire;
  bit    slot_fire;

  // Stimulus generator bookkeeping.
  logic [31:0] pid_pool [16];
  logic [63:0] pool_tk  [16];
  logic [63:0] sys_now;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic rank_insert(input logic [31:0] pid, input logic [63:0] dl,
                             input logic [MF_W-1:0] mf);
    int unsigned pos;
    int unsigned last_i;
    pos = top_n;
    for (int i = top_n - 1; i >= 0; i--) begin
      if (dl > top_dl[i]) pos = i;
    end
    if (pos < RANK_SLOTS) begin
      last_i = (top_n < RANK_SLOTS) ? top_n : RANK_SLOTS - 1;
      for (int i = last_i; i > pos; i--) begin
        top_pid[i] = top_pid[i-1];
        top_dl[i]  = top_dl[i-1];
        top_mf[i]  = top_mf[i-1];
      end
      top_pid[pos] = pid;
      top_dl[pos]  = dl;
      top_mf[pos]  = mf;
      if (top_n < RANK_SLOTS) top_n++;
    end
  endtask

  // Folds one accepted record into the state; at scan end queues five slots.
  task automatic rank_record(input rec_t r);
    logic [63:0]  mp;
    logic [2:0]   fl;
    logic [63:0]  sd;
    logic [63:0]  t2;
    logic [63:0]  dl;
    logic [MF_W-1:0] mf;
    logic [63:0]  cap;
    logic [127:0] prod;
    logic [63:0]  cpu;
    bit           hit;
    slot_t        s;
    if (r.proc_id != 0) begin
      rec_cnt++;
      if (cur_n < TABLE_DEPTH) begin
        mp = (mem_total != 0) ? ({24'd0, r.resident_kb} * 64'd100) / {24'd0, mem_total}
                              : 64'd0;
        if (mp > 255) mp = 255;
        fl = {r.privileged, r.state_code == ST_UNRESP, r.state_code == ST_ZOMBIE};
        cur_id[cur_n] = r.proc_id;
        cur_tk[cur_n] = r.cpu_ticks;
        cur_mf[cur_n] = {mp[7:0], fl};
        cur_n++;
      end
    end
    if (r.scan_last) begin
      top_n = 0;
      for (int k = 0; k < RANK_SLOTS; k++) begin
        top_pid[k] = '0;
        top_dl[k]  = '0;
        top_mf[k]  = '0;
      end
      sd = r.system_ticks - base_sys;
      if (sd == 0) sd = 1;
      for (int i = 0; i < base_n; i++) begin
        hit = 1'b0;
        t2  = '0;
        mf  = '0;
        for (int j = 0; j < cur_n && !hit; j++) begin
          if (cur_id[j] == base_id[i]) begin
            hit = 1'b1;
            t2  = cur_tk[j];
            mf  = cur_mf[j];
          end
        end
        if (t2 != 0) begin
          dl = (t2 >= base_tk[i]) ? t2 - base_tk[i] : 64'd0;
          rank_insert(base_id[i], dl, mf);
        end
      end
      cap = 64'd10000 * ((cpu_num == 0) ? 64'd1 : {53'd0, cpu_num});
      for (int k = 0; k < RANK_SLOTS; k++) begin
        s = '0;
        s.slot_index      = 3'(k);
        s.total_processes = rec_cnt;
        s.slot_last       = (k == RANK_SLOTS - 1);
        if (k < top_n && top_pid[k] != 0) begin
          if (top_dl[k] >= sd) cpu = cap;
          else begin
            prod = {64'd0, top_dl[k]} * {64'd0, cap};
            prod = prod / {64'd0, sd};
            cpu  = prod[63:0];
          end
          if (cpu > cap) cpu = cap;
          if (cpu > 64'hFFFF) cpu = 64'hFFFF;
          s.slot_pid       = top_pid[k];
          s.cpu_hundredths = cpu[15:0];
          s.memory_percent = top_mf[k][MF_W-1:3];
          s.status_flags   = top_mf[k][2:0];
        end
        expected_slots.push_back(s);
      end
      for (int j = 0; j < cur_n; j++) begin
        base_id[j] = cur_id[j];
        base_tk[j] = cur_tk[j];
      end
      base_n   = cur_n;
      base_sys = r.system_ticks;
      cur_n    = 0;
      rec_cnt  = '0;
    end
  endtask

  // Record driver: a new word may follow an accepted one in the same step.
  always @(negedge clk) begin
    if (rec_fire) begin
      rec_fire = 1'b0;
      rec_busy = 1'b0;
      rec_gap  = $urandom_range(0, max_gap);
    end
    if (!rst && !rec_busy) begin
      if (rec_gap == 0 && pending_recs.size() != 0) begin
        rec       <= pending_recs.pop_front();
        rec_valid <= 1'b1;
        rec_busy   = 1'b1;
      end else begin
        rec_valid <= 1'b0;
        if (rec_gap > 0) rec_gap--;
      end
    end
  end

  // Slot receiver stall.
  always @(negedge clk) begin
    if (slot_fire) begin
      slot_fire = 1'b0;
      slot_gap  = $urandom_range(0, max_gap);
    end
    slot_ready <= (slot_gap == 0);
    if (slot_gap > 0) slot_gap--;
  end

  always @(posedge clk) begin
    if (!rst && rec_valid && rec_ready) begin
      rank_record(rec);
      rec_fire = 1'b1;
    end
  end

  always @(posedge clk) begin
    slot_t want;
    if (!rst && slot_valid && slot_ready) begin
      slot_fire = 1'b1;
      slots_seen++;
      if (expected_slots.size() == 0) begin
        $display("%0t: unexpected slot word %p", $time, slot);
        errors++;
      end else begin
        want = expected_slots.pop_front();
        if (slot.slot_index !== want.slot_index) begin
          $display("%0t: slot_index exp %0d got %0d", $time, want.slot_index,
                   slot.slot_index);
          errors++;
        end
        if (slot.slot_pid !== want.slot_pid) begin
          $display("%0t: slot_pid exp %0h got %0h", $time, want.slot_pid, slot.slot_pid);
          errors++;
        end
        if (slot.cpu_hundredths !== want.cpu_hundredths) begin
          $display("%0t: cpu_hundredths exp %0d got %0d", $time, want.cpu_hundredths,
                   slot.cpu_hundredths);
          errors++;
        end
        if (slot.memory_percent !== want.memory_percent) begin
          $display("%0t: memory_percent exp %0d got %0d", $time, want.memory_percent,
                   slot.memory_percent);
          errors++;
        end
        if (slot.status_flags !== want.status_flags) begin
          $display("%0t: status_flags exp %0h got %0h", $time, want.status_flags,
                   slot.status_flags);
          errors++;
        end
        if (slot.total_processes !== want.total_processes) begin
          $display("%0t: total_processes exp %0d got %0d", $time, want.total_processes,
                   slot.total_processes);
          errors++;
        end
        if (slot.slot_last !== want.slot_last) begin
          $display("%0t: slot_last exp %0d got %0d", $time, want.slot_last,
                   slot.slot_last);
          errors++;
        end
      end
    end
  end

  task automatic push_rec(input logic [31:0] pid, input logic [63:0] tk,
                          input logic [7:0] st, input logic pv, input logic [39:0] rss,
                          input logic [63:0] sys, input logic last);
    rec_t r;
    r.proc_id      = pid;
    r.cpu_ticks    = tk;
    r.state_code   = st;
    r.privileged   = pv;
    r.resident_kb  = rss;
    r.system_ticks = sys;
    r.scan_last    = last;
    pending_recs.push_back(r);
    if (last) scans_sent++;
  endtask

  // Waits until every queued record is taken and every slot word has come.
  task automatic wait_idle();
    while (pending_recs.size() != 0 || rec_busy || expected_slots.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 4'(8 * int'(idx));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_MEM_TOTAL) mem_total = val[39:0];
    else cpu_num = val[10:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One scan over the pid pool: mostly advancing counters, with zero ticks,
  // counters that went back, ignored zero-id records and repeated ids mixed in.
  task automatic random_scan(input int n);
    int          p;
    logic [31:0] pid;
    logic [63:0] tk;
    logic [63:0] sys;
    logic [7:0]  st;
    logic [39:0] rss;
    for (int i = 0; i < n; i++) begin
      p   = $urandom_range(0, 15);
      pid = ($urandom_range(0, 11) == 0) ? 32'd0 : pid_pool[p];
      case ($urandom_range(0, 19))
        0:       tk = 64'd0;
        1:       tk = pool_tk[p] - $urandom_range(1, 500);
        2:       tk = {$urandom, $urandom};
        default: tk = pool_tk[p] + $urandom_range(0, 4000);
      endcase
      if (pid != 0) pool_tk[p] = tk;
      case ($urandom_range(0, 3))
        0:       st = ST_ZOMBIE;
        1:       st = ST_UNRESP;
        default: st = 8'($urandom);
      endcase
      rss = ($urandom_range(0, 3) == 0) ? 40'({$urandom, $urandom})
                                        : 40'($urandom_range(0, 2000000));
      sys = {$urandom, $urandom};
      if (i == n - 1) begin
        case ($urandom_range(0, 9))
          0:       sys = sys_now;
          1:       sys = {$urandom, $urandom};
          default: sys = sys_now + $urandom_range(1, 20000);
        endcase
        sys_now = sys;
      end
      push_rec(pid, tk, st, 1'($urandom), rss, sys, i == n - 1);
    end
  endtask

  initial begin
    int items;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rec_valid  = 1'b0;
    rec        = '0;
    slot_ready = 1'b0;
    errors     = 0;
    slots_seen = 0;
    scans_sent = 0;
    max_gap    = 12;
    rec_gap    = 0;
    slot_gap   = 0;
    rec_busy   = 1'b0;
    rec_fire   = 1'b0;
    slot_fire  = 1'b0;
    mem_total  = 40'd1;
    cpu_num    = 11'd1;
    base_n     = 0;
    cur_n      = 0;
    base_sys   = '0;
    rec_cnt    = '0;
    top_n      = 0;
    sys_now    = 64'd1000;
    for (int i = 0; i < 16; i++) begin
      pid_pool[i] = $urandom_range(1, 32'h7FFFFFFF) | (i << 27);
      pool_tk[i]  = 64'($urandom_range(0, 100000));
    end
    pid_pool[0] = 32'hFFFFFFFF;
    pid_pool[1] = 32'd1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    reg_write(REG_MEM_TOTAL, 64'd1000);
    reg_write(REG_CPU_COUNT, 64'd1);

    // First scan only sets the baseline; its last record has a zero id.
    push_rec(32'hFFFFFFFF, 64'd100, ST_ZOMBIE, 1'b1, 40'hFF_FFFF_FFFF, 64'd0, 1'b0);
    push_rec(32'd1, 64'd200, ST_UNRESP, 1'b0, 40'd0, 64'd0, 1'b0);
    push_rec(32'd7, 64'd300, 8'h00, 1'b0, 40'd5, 64'd0, 1'b0);
    push_rec(32'd9, 64'd400, 8'hFF, 1'b1, 40'd999, 64'd0, 1'b0);
    push_rec(32'd11, 64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 1'b0, 40'd10, 64'd0, 1'b0);
    push_rec(32'd0, 64'd1, 8'h44, 1'b1, 40'd3, 64'd1000, 1'b1);
    // Second scan: id 9 missing, id 7 at zero ticks, id 11 went back,
    // plus one fresh id and as many nonzero ids as slots.
    push_rec(32'd1, 64'd900, ST_UNRESP, 1'b0, 40'd500, 64'd0, 1'b0);
    push_rec(32'hFFFFFFFF, 64'd5000, ST_ZOMBIE, 1'b1, 40'd12, 64'd0, 1'b0);
    push_rec(32'd7, 64'd0, 8'h00, 1'b0, 40'd1, 64'd0, 1'b0);
    push_rec(32'd11, 64'd5, 8'h00, 1'b0, 40'd1, 64'd0, 1'b0);
    push_rec(32'd0, 64'd77, 8'h5A, 1'b1, 40'd7, 64'd0, 1'b0);
    push_rec(32'd20, 64'd50, 8'h52, 1'b0, 40'd1, 64'd1800, 1'b1);
    // Third scan: zero system delta, the whole delta beyond the system total.
    push_rec(32'd1, 64'd2000, 8'h53, 1'b0, 40'd1000, 64'd0, 1'b0);
    push_rec(32'd20, 64'd60, 8'h53, 1'b1, 40'd2, 64'd1800, 1'b1);
    wait_idle();

    // Wide settings: saturating CPU clamp across many processors.
    reg_write(REG_MEM_TOTAL, 64'hFF_FFFF_FFFF);
    reg_write(REG_CPU_COUNT, 64'd1024);
    items = 0;
    while (items < 70) begin
      int n;
      n = $urandom_range(1, 12);
      random_scan(n);
      items += n;
    end
    wait_idle();

    // Zero registers: memory percent forced to zero, one processor assumed.
    reg_write(REG_MEM_TOTAL, 64'd0);
    reg_write(REG_CPU_COUNT, 64'd0);
    max_gap = 0;
    items = 0;
    while (items < 60) begin
      int n;
      n = $urandom_range(1, 12);
      random_scan(n);
      items += n;
    end
    wait_idle();
    max_gap = 12;

    // Tiny memory total and four processors.
    reg_write(REG_MEM_TOTAL, 64'd1);
    reg_write(REG_CPU_COUNT, 64'd4);
    random_scan(6);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_MEM_TOTAL, (ph == 3) ? 64'd1 : 64'($urandom_range(1, 32'h3FFFFF)));
      reg_write(REG_CPU_COUNT, (ph == 3) ? 64'd1 : 64'($urandom_range(1, 1024)));
      items = 0;
      while (items < 60) begin
        int n;
        n = $urandom_range(1, 14);
        random_scan(n);
        items += n;
      end
      wait_idle();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d scans and %0d slot words over eight register settings,",
             scans_sent, slots_seen);
    $display("including first scans, zero ids, zero registers and clamped CPU usage.");
    if (errors == 0) begin
      $display("snapshot_delta_top_k_ranker_core: match");
    end else begin
      $display("snapshot_delta_top_k_ranker_core: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("snapshot_delta_top_k_ranker_core: mismatch");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/snp_pkg.sv
hw/rtl/snp_ram.sv
hw/rtl/snp_dp.sv
hw/rtl/snp_ctrl.sv
hw/rtl/snapshot_delta_top_k_ranker_core.sv
verif/snapshot_delta_top_k_ranker_core_tb.sv
